// ===== hdl/wsd_pkg.sv =====
// wsd_pkg: shared types and constants for the WebSocket frame deframer.
// No dependencies; imported by every module under hdl/.
package wsd_pkg;

    localparam int unsigned MAX_PAY_W      = 21;
    localparam logic [MAX_PAY_W-1:0] MAX_PAY_RESET = MAX_PAY_W'(1 << 20);
    localparam int unsigned QUEUE_DEPTH    = 4;

    localparam logic [3:0] OPC_CLOSE = 4'h8;
    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_CLOSED  = 2'd1;
    localparam logic [1:0] ST_REFUSED = 2'd2;

    // One classified transaction handed from front to back.
    typedef struct packed {
        logic [7:0] raw;     // received byte, zero for header-end results
        logic [7:0] key;     // mask byte to apply, zero when unmasked
        logic [3:0] opcode;
        logic       valid;   // payload byte present
        logic       last;
        logic [1:0] status;
    } t_entry;

    typedef struct packed {
        logic push;
        logic halted;
    } t_front_stat;

endpackage

// ===== hdl/wsd_front.sv =====
// wsd_front: header parser and byte classifier; owns the max_payload register.
// Depends on wsd_pkg.
module wsd_front
    import wsd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [MAX_PAY_W-1:0] i_cfg_wdata,
    input  logic                 i_acc,
    input  logic [7:0]           i_byte,
    output t_entry               o_entry,
    output t_front_stat          o_stat
);

    localparam logic [2:0] PH_HDR0 = 3'd0;
    localparam logic [2:0] PH_HDR1 = 3'd1;
    localparam logic [2:0] PH_EXT  = 3'd2;
    localparam logic [2:0] PH_MASK = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;
    localparam logic [2:0] PH_HALT = 3'd5;

    logic [MAX_PAY_W-1:0] r_max;
    logic [2:0]  r_phase, n_phase;
    logic [3:0]  r_opc, n_opc;
    logic        r_mask, n_mask;
    logic [63:0] r_len, n_len;
    logic [2:0]  r_cnt, n_cnt;
    logic [31:0] r_key, n_key;

    logic [63:0]          len_hd;     // length seen by the header-end check
    logic                 hd_fire;    // header completes on this byte
    logic                 oversize;
    logic [MAX_PAY_W-1:0] len_dec;
    logic                 push;
    t_entry               ent;

    assign oversize = (|len_hd[63:MAX_PAY_W]) || (len_hd[MAX_PAY_W-1:0] > r_max);
    assign len_dec  = r_len[MAX_PAY_W-1:0] - MAX_PAY_W'(1);

    always_comb begin
        n_phase = r_phase;
        n_opc   = r_opc;
        n_mask  = r_mask;
        n_len   = r_len;
        n_cnt   = r_cnt;
        n_key   = r_key;
        len_hd  = r_len;
        hd_fire = 1'b0;
        push    = 1'b0;
        ent     = '{raw: 8'd0, key: 8'd0, opcode: r_opc, valid: 1'b0,
                    last: 1'b0, status: ST_OK};
        if (i_acc) begin
            unique case (r_phase)
                PH_HDR0: begin
                    n_opc   = i_byte[3:0];
                    n_phase = PH_HDR1;
                end
                PH_HDR1: begin
                    n_mask = i_byte[7];
                    n_len  = '0;
                    if (i_byte[6:0] == LEN7_EXT16) begin
                        n_cnt   = 3'd1;
                        n_phase = PH_EXT;
                    end else if (i_byte[6:0] == LEN7_EXT64) begin
                        n_cnt   = 3'd7;
                        n_phase = PH_EXT;
                    end else begin
                        n_len  = {57'd0, i_byte[6:0]};
                        len_hd = n_len;
                        if (i_byte[7]) begin
                            n_cnt   = 3'd3;
                            n_key   = '0;
                            n_phase = PH_MASK;
                        end else begin
                            hd_fire = 1'b1;
                        end
                    end
                end
                PH_EXT: begin
                    n_len  = {r_len[55:0], i_byte};
                    len_hd = n_len;
                    if (r_cnt != 3'd0) begin
                        n_cnt = r_cnt - 3'd1;
                    end else if (r_mask) begin
                        n_cnt   = 3'd3;
                        n_key   = '0;
                        n_phase = PH_MASK;
                    end else begin
                        hd_fire = 1'b1;
                    end
                end
                PH_MASK: begin
                    n_key = {r_key[23:0], i_byte};
                    if (r_cnt != 3'd0) begin
                        n_cnt = r_cnt - 3'd1;
                    end else begin
                        hd_fire = 1'b1;
                    end
                end
                PH_DATA: begin
                    // key register rotates so the active mask byte is always on top
                    n_key     = {r_key[23:0], r_key[31:24]};
                    n_len     = {r_len[63:MAX_PAY_W], len_dec};
                    push      = 1'b1;
                    ent.raw   = i_byte;
                    ent.key   = r_mask ? r_key[31:24] : 8'd0;
                    ent.valid = 1'b1;
                    if (len_dec == '0) begin
                        ent.last = 1'b1;
                        if (r_opc == OPC_CLOSE) begin
                            ent.status = ST_CLOSED;
                            n_phase    = PH_HALT;
                        end else begin
                            n_phase = PH_HDR0;
                        end
                    end
                end
                default: n_phase = PH_HALT;
            endcase

            if (hd_fire) begin
                priority if (oversize) begin
                    push       = 1'b1;
                    ent.status = ST_REFUSED;
                    n_phase    = PH_HALT;
                end else if (len_hd == 64'd0) begin
                    push     = 1'b1;
                    ent.last = 1'b1;
                    if (r_opc == OPC_CLOSE) begin
                        ent.status = ST_CLOSED;
                        n_phase    = PH_HALT;
                    end else begin
                        n_phase = PH_HDR0;
                    end
                end else begin
                    n_phase = PH_DATA;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max   <= MAX_PAY_RESET;
            r_phase <= PH_HDR0;
            r_opc   <= '0;
            r_mask  <= 1'b0;
            r_len   <= '0;
            r_cnt   <= '0;
            r_key   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_max <= i_cfg_wdata;
            end
            r_phase <= n_phase;
            r_opc   <= n_opc;
            r_mask  <= n_mask;
            r_len   <= n_len;
            r_cnt   <= n_cnt;
            r_key   <= n_key;
        end
    end

    assign o_entry       = ent;
    assign o_stat.push   = push;
    assign o_stat.halted = (r_phase == PH_HALT);

endmodule

// ===== hdl/wsd_queue.sv =====
// wsd_queue: short register FIFO of classified entries between front and back.
// Depends on wsd_pkg.
module wsd_queue
    import wsd_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output t_entry o_entry,
    output logic   o_nonempty,
    output logic   o_full
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr, r_rd;
    logic [CNT_W-1:0]   r_cnt;
    logic               do_push, do_pop;

    assign o_full     = (r_cnt == CNT_W'(DEPTH));
    assign o_nonempty = (r_cnt != '0);
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && o_nonempty;
    assign o_entry    = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            unique case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== hdl/wsd_back.sv =====
// wsd_back: unmasks queued entries and holds the result in the output register.
// Depends on wsd_pkg.
module wsd_back
    import wsd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_entry     i_entry,
    input  logic       i_avail,
    output logic       o_pop,
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,
    output logic       o_m_tlast,
    output logic [7:0] o_m_tuser
);

    logic       r_valid;
    logic [7:0] r_data;
    logic [3:0] r_opc;
    logic       r_dv;
    logic       r_last;
    logic [1:0] r_status;
    logic       load;

    assign load  = i_avail && (!r_valid || i_m_tready);
    assign o_pop = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data   <= i_entry.raw ^ i_entry.key;
            r_opc    <= i_entry.opcode;
            r_dv     <= i_entry.valid;
            r_last   <= i_entry.last;
            r_status <= i_entry.status;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_data;
    assign o_m_tlast  = r_last;
    assign o_m_tuser  = {1'b0, r_status, r_dv, r_opc};

endmodule

// ===== hdl/websocket_frame_deframer.sv =====
// websocket_frame_deframer: top level, front parser + queue + output stage.
// Depends on wsd_pkg, wsd_front, wsd_queue, wsd_back.
//
// Receives a WebSocket (RFC 6455) byte stream one byte per transaction and
// emits one result per payload byte, unmasked, tagged with the frame opcode
// and a last flag. Header bytes give no result, except that the header of
// an empty frame ends in one empty result with tlast set, and a frame whose
// length exceeds max_payload ends in one refused result (status 2), after
// which the block halts. A close frame (opcode 8) halts after its last byte
// (status 1). While halted every byte is accepted and dropped until reset.
// FIN and RSV bits are ignored. Throughput is one byte per clock while the
// queue is not full. Each accepted byte is classified combinationally and its
// entry is written into a queue slot at the accepting edge; the entry then
// moves to the output register once that register is empty or tready is high.
// The front takes a byte whenever the queue has room, so downstream stalls are
// absorbed by the queue and the output register before tready drops.
module websocket_frame_deframer
    import wsd_pkg::*;
#(
    parameter int unsigned Q_DEPTH = QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration: max_payload
    input  logic                 i_cfg_we,
    input  logic [MAX_PAY_W-1:0] i_cfg_wdata,
    // receive stream
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [7:0]           i_s_tdata,   // [7:0] rx_byte
    // result stream
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [7:0]           o_m_tdata,   // [7:0] data_byte
    output logic                 o_m_tlast,   // frame_last
    output logic [7:0]           o_m_tuser    // [3:0] frame_opcode, [4] data_valid,
                                              // [6:5] status, [7] zero
);

    t_entry      w_front_ent;
    t_entry      w_q_ent;
    t_front_stat w_stat;
    logic        w_acc;
    logic        w_q_full;
    logic        w_q_nonempty;
    logic        w_pop;

    // Any accepted byte may produce an entry, so only a full queue stalls input.
    assign o_s_tready = !w_q_full;
    assign w_acc      = i_s_tvalid && o_s_tready;

    wsd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_acc       (w_acc),
        .i_byte      (i_s_tdata),
        .o_entry     (w_front_ent),
        .o_stat      (w_stat)
    );

    wsd_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_stat.push),
        .i_entry    (w_front_ent),
        .i_pop      (w_pop),
        .o_entry    (w_q_ent),
        .o_nonempty (w_q_nonempty),
        .o_full     (w_q_full)
    );

    wsd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_entry    (w_q_ent),
        .i_avail    (w_q_nonempty),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    // A halted parser never produces another entry.
    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.halted |-> !w_stat.push)
        else $error("entry pushed while halted");

    // Halt is sticky until reset.
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.halted |=> w_stat.halted)
        else $error("left halt without reset");

    // A close status only comes with the frame end.
    a_close_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[6:5] == ST_CLOSED) |-> o_m_tlast)
        else $error("close status without tlast");

    // Results without payload carry a zero data byte.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[4]) |-> (o_m_tdata == 8'd0))
        else $error("nonzero data on empty result");

endmodule
